[rtl/tmcw_pkg.sv]
// shared constants, types and helpers of the text mode console writer
`timescale 1ns / 1ps

package tmcw_pkg;

   // grid geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;
   localparam int SHIFT_N = COLUMNS * (ROWS - 1);

   // internal and field widths
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(COLUMNS);
   localparam int ROW_W  = $clog2(ROWS);
   localparam int COL_FW = 7;
   localparam int ROW_FW = 5;
   localparam int CODE_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;

   // control characters
   localparam logic [CODE_W-1:0] CODE_NEWLINE   = 8'd10;
   localparam logic [CODE_W-1:0] CODE_RETURN    = 8'd13;
   localparam logic [CODE_W-1:0] CODE_TAB       = 8'd9;
   localparam logic [CODE_W-1:0] CODE_BACKSPACE = 8'd8;
   localparam logic [CODE_W-1:0] CODE_SPACE     = 8'd32;
   localparam int                TAB_STEP       = 4;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   typedef enum logic [1:0] {
      OP_PUT   = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CK_NEWLINE,
      CK_RETURN,
      CK_TAB,
      CK_BACKSPACE,
      CK_PRINT
   } char_kind_type;

   // one classified request
   typedef struct packed {
      op_type              op;
      char_kind_type       kind;
      logic [CODE_W-1:0]   code;
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
   } cmd_type;

   // linear cell address of a grid position
   function automatic logic [ADDR_W-1:0] cell_addr(input logic [COL_W-1:0] col,
                                                   input logic [ROW_W-1:0] row);
      cell_addr = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

[rtl/text_mode_console_writer.sv]
// top level of the text mode console writer
//
// Usage: requests enter on the req_ channel (valid/ready) and each one gives
// exactly one response on the rsp_ channel, in order. The csr_ port writes the
// text attribute used for printed and blanked cells; it is always ready. The
// user must write it only while no request is in flight; the block does not
// enforce this. A request passes the front decode into a two-entry queue, so
// the req_ side keeps accepting while a finished response waits in the output
// register.
// A read cell waits on the registered memory read; clear screen and a put
// character that scrolls walk the cell memory before their response.
// The back end works on one request at a time and takes the next from the
// queue only after loading the response register.
// After reset the cell memory is swept to blanks with attribute 0x07, one
// cell per cycle over all CELLS (2000) cells; req_ready stays low meanwhile.
// When rsp_ready is low the response holds and the back end waits; the queue
// fills and then req_ready drops.
`timescale 1ns / 1ps

module text_mode_console_writer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [1:0]   req_operation,
   input  logic [7:0]   req_char_code,
   input  logic [6:0]   req_target_column,
   input  logic [4:0]   req_target_row,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [6:0]   rsp_cursor_column,
   output logic [4:0]   rsp_cursor_row,
   output logic [15:0]  rsp_cell_value,
   output logic         rsp_scrolled,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_text_attribute
);
   import tmcw_pkg::*;

   logic [ATTR_W-1:0]  attr_ff;
   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_valid;
   logic               init_busy;
   cmd_type            push_cmd;
   cmd_type            head_cmd;

   // attribute register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_valid && csr_ready) begin
         attr_ff <= csr_text_attribute;
      end
   end

   tmcw_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_char_code     (req_char_code),
      .req_target_column (req_target_column),
      .req_target_row    (req_target_row),
      .q_full            (q_full),
      .init_busy         (init_busy),
      .q_push            (q_push),
      .q_cmd             (push_cmd)
   );

   tmcw_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (head_cmd)
   );

   tmcw_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_cmd             (head_cmd),
      .q_pop             (q_pop),
      .attr              (attr_ff),
      .init_busy         (init_busy),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cell_value    (rsp_cell_value),
      .rsp_scrolled      (rsp_scrolled)
   );

   // a scrolling response leaves the cursor on the bottom row
   a_scroll_bottom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> int'(rsp_cursor_row) == ROWS - 1)
      else $error("scrolled response with cursor off the bottom row");

   // only a read carries cell data, and a read never scrolls
   a_scroll_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cell_value == '0)
      else $error("scrolled response carries cell data");

   // the cursor stays inside the grid
   a_cursor_in_grid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> int'(rsp_cursor_column) < COLUMNS && int'(rsp_cursor_row) < ROWS)
      else $error("cursor outside the grid");

endmodule

[rtl/tmcw_front.sv]
// request intake: handshake, control character decode and target clamping
`timescale 1ns / 1ps

module tmcw_front (
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [7:0]           req_char_code,
   input  logic [6:0]           req_target_column,
   input  logic [4:0]           req_target_row,
   input  logic                 q_full,
   input  logic                 init_busy,
   output logic                 q_push,
   output tmcw_pkg::cmd_type    q_cmd
);
   import tmcw_pkg::*;

   // take a request while the queue has room and the startup clear is done
   assign req_ready = !q_full && !init_busy;
   assign q_push    = req_valid && req_ready;

   // classify the request
   always_comb begin
      q_cmd.op   = op_type'(req_operation);
      q_cmd.code = req_char_code;
      case (req_char_code)
         CODE_NEWLINE:   q_cmd.kind = CK_NEWLINE;
         CODE_RETURN:    q_cmd.kind = CK_RETURN;
         CODE_TAB:       q_cmd.kind = CK_TAB;
         CODE_BACKSPACE: q_cmd.kind = CK_BACKSPACE;
         default:        q_cmd.kind = CK_PRINT;
      endcase
      if (int'(req_target_column) >= COLUMNS) begin
         q_cmd.col = COL_W'(COLUMNS - 1);
      end else begin
         q_cmd.col = COL_W'(req_target_column);
      end
      if (int'(req_target_row) >= ROWS) begin
         q_cmd.row = ROW_W'(ROWS - 1);
      end else begin
         q_cmd.row = ROW_W'(req_target_row);
      end
   end

endmodule

[rtl/tmcw_queue.sv]
// two-entry queue of classified requests between front and back
`timescale 1ns / 1ps

module tmcw_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tmcw_pkg::cmd_type    push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output tmcw_pkg::cmd_type    pop_data
);
   import tmcw_pkg::*;

   cmd_type     slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/tmcw_back.sv]
// execution side: cell memory, cursor, scroll and fill walkers, response register
`timescale 1ns / 1ps

module tmcw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  tmcw_pkg::cmd_type    q_cmd,
   output logic                 q_pop,
   input  logic [7:0]           attr,
   output logic                 init_busy,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [6:0]           rsp_cursor_column,
   output logic [4:0]           rsp_cursor_row,
   output logic [15:0]          rsp_cell_value,
   output logic                 rsp_scrolled
);
   import tmcw_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SHIFT,
      ST_FILL,
      ST_EMIT
   } state_type;

   state_type             state_ff;
   logic [COL_W-1:0]      col_ff;
   logic [ROW_W-1:0]      row_ff;
   logic [ADDR_W-1:0]     idx_ff;
   logic                  fill_emit_ff;
   logic [CELL_W-1:0]     fill_val_ff;
   logic                  pend_ff;
   logic [ADDR_W-1:0]     pend_dst_ff;
   logic [CELL_W-1:0]     res_value_ff;
   logic                  res_scrolled_ff;
   logic                  rsp_valid_ff;
   logic [COL_FW-1:0]     rsp_col_ff;
   logic [ROW_FW-1:0]     rsp_row_ff;
   logic [CELL_W-1:0]     rsp_value_ff;
   logic                  rsp_scrolled_ff;

   logic [CELL_W-1:0]     cells_ff [CELLS];
   logic [CELL_W-1:0]     rd_data_ff;

   logic                  mem_we;
   logic [ADDR_W-1:0]     mem_waddr;
   logic [CELL_W-1:0]     mem_wdata;
   logic [ADDR_W-1:0]     mem_raddr;

   logic [COL_W:0]        pc_col;
   logic [ROW_W:0]        pc_row;
   logic                  pc_we;
   logic [ADDR_W-1:0]     pc_addr;
   logic [CELL_W-1:0]     pc_data;
   logic                  pc_scroll;

   assign q_pop             = (state_ff == ST_IDLE) && q_valid;
   assign init_busy         = (state_ff == ST_FILL) && !fill_emit_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_column = rsp_col_ff;
   assign rsp_cursor_row    = rsp_row_ff;
   assign rsp_cell_value    = rsp_value_ff;
   assign rsp_scrolled      = rsp_scrolled_ff;

   // cursor motion and cell write of a put character
   always_comb begin
      pc_col  = {1'b0, col_ff};
      pc_row  = {1'b0, row_ff};
      pc_we   = 1'b0;
      pc_addr = cell_addr(col_ff, row_ff);
      pc_data = {attr, q_cmd.code};
      case (q_cmd.kind)
         CK_NEWLINE: begin
            pc_col = '0;
            pc_row = pc_row + 1'b1;
         end
         CK_RETURN: begin
            pc_col = '0;
         end
         CK_TAB: begin
            pc_col = (pc_col + (COL_W + 1)'(TAB_STEP)) & ~((COL_W + 1)'(TAB_STEP - 1));
         end
         CK_BACKSPACE: begin
            if (col_ff != '0) begin
               pc_col  = pc_col - 1'b1;
               pc_we   = 1'b1;
               pc_addr = cell_addr(col_ff - 1'b1, row_ff);
               pc_data = {attr, CODE_SPACE};
            end
         end
         CK_PRINT: begin
            pc_we  = 1'b1;
            pc_col = pc_col + 1'b1;
         end
         default: begin
         end
      endcase
      if (pc_col >= (COL_W + 1)'(COLUMNS)) begin
         pc_col = '0;
         pc_row = pc_row + 1'b1;
      end
      pc_scroll = (pc_row >= (ROW_W + 1)'(ROWS));
   end

   // memory port selection
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = pc_addr;
      mem_wdata = pc_data;
      mem_raddr = cell_addr(q_cmd.col, q_cmd.row);
      case (state_ff)
         ST_IDLE: begin
            mem_we = q_valid && (q_cmd.op == OP_PUT) && pc_we;
         end
         ST_SHIFT: begin
            mem_we    = pend_ff;
            mem_waddr = pend_dst_ff;
            mem_wdata = rd_data_ff;
            mem_raddr = idx_ff + ADDR_W'(COLUMNS);
         end
         ST_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = fill_val_ff;
         end
         default: begin
         end
      endcase
   end

   // cell memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= cells_ff[mem_raddr];
   end

   // sequencer, cursor and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         idx_ff       <= '0;
         fill_emit_ff <= 1'b0;
         fill_val_ff  <= {ATTR_RESET, CODE_SPACE};
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // response taken; in emit the load below decides
         if (rsp_valid_ff && rsp_ready && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  res_value_ff    <= '0;
                  res_scrolled_ff <= 1'b0;
                  case (q_cmd.op)
                     OP_PUT: begin
                        col_ff <= pc_col[COL_W-1:0];
                        if (pc_scroll) begin
                           row_ff          <= ROW_W'(ROWS - 1);
                           idx_ff          <= '0;
                           res_scrolled_ff <= 1'b1;
                           state_ff        <= ST_SHIFT;
                        end else begin
                           row_ff   <= pc_row[ROW_W-1:0];
                           state_ff <= ST_EMIT;
                        end
                     end
                     OP_SET: begin
                        col_ff   <= q_cmd.col;
                        row_ff   <= q_cmd.row;
                        state_ff <= ST_EMIT;
                     end
                     OP_CLEAR: begin
                        col_ff       <= '0;
                        row_ff       <= '0;
                        idx_ff       <= '0;
                        fill_val_ff  <= {attr, CODE_SPACE};
                        fill_emit_ff <= 1'b1;
                        state_ff     <= ST_FILL;
                     end
                     OP_READ: begin
                        state_ff <= ST_READ;
                     end
                     default: begin
                        state_ff <= ST_EMIT;
                     end
                  endcase
               end
            end
            ST_READ: begin
               res_value_ff <= rd_data_ff;
               state_ff     <= ST_EMIT;
            end
            ST_SHIFT: begin
               // read one row down, write it back in the next cycle
               pend_ff     <= (idx_ff < ADDR_W'(SHIFT_N));
               pend_dst_ff <= idx_ff;
               if (idx_ff == ADDR_W'(SHIFT_N)) begin
                  fill_val_ff  <= {attr, CODE_SPACE};
                  fill_emit_ff <= 1'b1;
                  state_ff     <= ST_FILL;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_FILL: begin
               if (idx_ff == ADDR_W'(CELLS - 1)) begin
                  state_ff <= fill_emit_ff ? ST_EMIT : ST_IDLE;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            ST_EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff    <= 1'b1;
                  rsp_col_ff      <= COL_FW'(col_ff);
                  rsp_row_ff      <= ROW_FW'(row_ff);
                  rsp_value_ff    <= res_value_ff;
                  rsp_scrolled_ff <= res_scrolled_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule
